// File: hdl/cpc_pkg.sv
`timescale 1ns / 1ps

package cpc_pkg;

  // Datapath words carry 4 extra fraction bits over Q10.8 (Q.12).
  localparam int GUARD = 4;
  localparam int DW    = 26;   // x / y working width, signed
  localparam int ZW    = 24;   // angle accumulator, Q.20 radians, signed
  localparam int GAINW = 21;   // 1/K as a signed constant
  localparam int PW    = DW + GAINW;

  localparam int TABLE_LEN = 24;

  localparam logic signed [GAINW-1:0] INV_GAIN_Q20  = 21'sd636751;
  localparam logic        [16:0]      DEFAULT_ANGLE = 17'd8579;   // pi/6 in Q2.14
  localparam logic        [16:0]      HALF_PI_Q14   = 17'd25736;
  localparam logic        [17:0]      RADIUS_MAX    = 18'h3FFFF;
  localparam logic        [16:0]      COORD_MAX     = 17'h1FFFF;

  typedef enum logic {
    OP_TO_POLAR = 1'b0,
    OP_TO_RECT  = 1'b1
  } cpc_op_t;

  // One transaction as it moves down the rotation array.
  typedef struct packed {
    cpc_op_t              op;
    logic                 bypass;   // special case, result fixed at the end
    logic                 flag;     // operands rejected
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } cpc_item_t;

  // atan(2^-i) in Q.20, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q20(input int unsigned idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = 24'sd823550;
      1:       v = 24'sd486170;
      2:       v = 24'sd256879;
      3:       v = 24'sd130396;
      4:       v = 24'sd65451;
      5:       v = 24'sd32757;
      6:       v = 24'sd16383;
      7:       v = 24'sd8192;
      8:       v = 24'sd4096;
      9:       v = 24'sd2048;
      10:      v = 24'sd1024;
      11:      v = 24'sd512;
      12:      v = 24'sd256;
      13:      v = 24'sd128;
      14:      v = 24'sd64;
      15:      v = 24'sd32;
      16:      v = 24'sd16;
      17:      v = 24'sd8;
      18:      v = 24'sd4;
      19:      v = 24'sd2;
      20:      v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/cpc_pre.sv
`timescale 1ns / 1ps

module cpc_pre
  import cpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [17:0] coord_a,
  input  logic [17:0] coord_b,
  output logic        out_valid,
  input  logic        out_ready,
  output cpc_item_t   out_item
);

  logic        a_neg, b_neg, at_origin, angle_big;
  logic [40:0] rot_prod;
  logic [41:0] rot_sum;
  logic [21:0] rot_x;
  cpc_item_t   item_next;

  assign in_ready = !out_valid || out_ready;

  assign a_neg     = coord_a[17];
  assign b_neg     = coord_b[17];
  assign at_origin = (coord_a == '0) && (coord_b == '0);
  assign angle_big = !b_neg && (coord_b[16:0] >= HALF_PI_Q14);

  // Rotation input is prescaled by 1/K: round((r << 4) * 1/K >> 20).
  assign rot_prod = {20'd0, coord_a[16:0], 4'd0} * {21'd0, INV_GAIN_Q20[19:0]};
  assign rot_sum  = {1'b0, rot_prod} + 42'd524288;
  assign rot_x    = rot_sum[41:20];

  always_comb begin
    item_next.op = cpc_op_t'(opcode);
    if (cpc_op_t'(opcode) == OP_TO_POLAR) begin
      item_next.flag   = a_neg || b_neg;
      item_next.bypass = a_neg || b_neg || at_origin;
      item_next.x      = {{(DW-22){coord_a[17]}}, coord_a, 4'd0};
      item_next.y      = {{(DW-22){coord_b[17]}}, coord_b, 4'd0};
      item_next.z      = '0;
    end else begin
      item_next.flag   = a_neg || b_neg || angle_big;
      item_next.bypass = a_neg || b_neg || angle_big;
      item_next.x      = {{(DW-22){1'b0}}, rot_x};
      item_next.y      = '0;
      item_next.z      = {coord_b, 6'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// File: hdl/cpc_step.sv
`timescale 1ns / 1ps

module cpc_step
  import cpc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cpc_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output cpc_item_t out_item
);

  logic signed [DW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic                 toward_neg;   // x += ys, y -= xs, z += atan
  cpc_item_t            item_next;

  assign in_ready = !out_valid || out_ready;

  assign xs = in_item.x >>> STEP;
  assign ys = in_item.y >>> STEP;
  assign at = atan_q20(STEP);

  // Vectoring drives y to zero, rotation drives z to zero.
  assign toward_neg = (in_item.op == OP_TO_POLAR) ? !in_item.y[DW-1] : in_item.z[ZW-1];

  always_comb begin
    item_next = in_item;
    if (toward_neg) begin
      item_next.x = in_item.x + ys;
      item_next.y = in_item.y - xs;
      item_next.z = in_item.z + at;
    end else begin
      item_next.x = in_item.x - ys;
      item_next.y = in_item.y + xs;
      item_next.z = in_item.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// File: hdl/cpc_post.sv
`timescale 1ns / 1ps

module cpc_post
  import cpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cpc_item_t   in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [17:0] result_a,
  output logic [16:0] result_b,
  output logic        origin_substituted
);

  // Stage A: gain correction product.
  logic                 va;
  logic                 ready_a;
  cpc_item_t            item_a;
  logic signed [PW-1:0] prod_a;

  // Stage B: rounding, clamping, special cases.
  logic                 ready_b;
  logic signed [PW-1:0] rad_full;
  logic signed [ZW-1:0] ang_full;
  logic signed [DW-1:0] xr_full, yr_full;
  logic [17:0]          radius;
  logic [16:0]          angle, xr, yr;
  logic [17:0]          result_a_next;
  logic [16:0]          result_b_next;

  assign ready_b  = !out_valid || out_ready;
  assign ready_a  = !va || ready_b;
  assign in_ready = ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      item_a <= in_item;
      prod_a <= PW'(in_item.x) * PW'(INV_GAIN_Q20);
    end
  end

  assign rad_full = (prod_a + (PW'(1) <<< 23)) >>> 24;
  assign ang_full = (item_a.z + ZW'(32)) >>> 6;
  assign xr_full  = (item_a.x + DW'(8)) >>> GUARD;
  assign yr_full  = (item_a.y + DW'(8)) >>> GUARD;

  always_comb begin
    if (rad_full[PW-1]) begin
      radius = '0;
    end else if (rad_full > PW'(RADIUS_MAX)) begin
      radius = RADIUS_MAX;
    end else begin
      radius = rad_full[17:0];
    end

    if (ang_full[ZW-1]) begin
      angle = '0;
    end else if (ang_full > ZW'(HALF_PI_Q14)) begin
      angle = HALF_PI_Q14;
    end else begin
      angle = ang_full[16:0];
    end

    if (xr_full[DW-1]) begin
      xr = '0;
    end else if (xr_full > DW'(COORD_MAX)) begin
      xr = COORD_MAX;
    end else begin
      xr = xr_full[16:0];
    end

    if (yr_full[DW-1]) begin
      yr = '0;
    end else if (yr_full > DW'(COORD_MAX)) begin
      yr = COORD_MAX;
    end else begin
      yr = yr_full[16:0];
    end

    if (item_a.op == OP_TO_POLAR) begin
      result_a_next = item_a.bypass ? '0 : radius;
      result_b_next = item_a.bypass ? DEFAULT_ANGLE : angle;
    end else begin
      result_a_next = item_a.bypass ? '0 : {1'b0, xr};
      result_b_next = item_a.bypass ? '0 : yr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_b) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && va) begin
      result_a           <= result_a_next;
      result_b           <= result_b_next;
      origin_substituted <= item_a.flag;
    end
  end

endmodule

// File: hdl/cartesian_polar_converter.sv
`timescale 1ns / 1ps

// First-quadrant CORDIC coordinate converter. opcode 0 takes x, y (signed
// Q10.8) and returns the radius (Q10.8) and atan(y/x) (Q2.14 radians);
// opcode 1 takes a radius (Q10.8) and an angle (Q2.14, below pi/2) and
// returns r*cos and r*sin (Q10.8). Negative operands or an angle of pi/2
// or more are replaced by the origin and origin_substituted is set; a true
// origin in vectoring mode returns angle pi/6 with the flag clear. The
// block is fully pipelined with one register stage per CORDIC iteration:
// it accepts one transaction every cycle unless the result port stalls, and
// has NSTEPS + 3 register stages, NSTEPS being ROTATION_STEPS capped at
// TABLE_LEN (one for input classification and the 1/K prescale multiply,
// one per iteration, one for the vectoring gain multiply and one for
// rounding and clamping).
// Every stage holds its own valid bit, so empty stages keep filling while
// the result port is stalled; item_ready is a combinational function of
// result_ready through that chain of stage valids.

module cartesian_polar_converter
  import cpc_pkg::*;
#(
  parameter int ROTATION_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,

  // Input transaction
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        opcode,
  input  logic [17:0] coord_a,
  input  logic [17:0] coord_b,

  // Result transaction
  output logic        result_valid,
  input  logic        result_ready,
  output logic [17:0] result_a,
  output logic [16:0] result_b,
  output logic        origin_substituted
);

  // Iterations beyond the arctangent table add nothing.
  localparam int NSTEPS = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;

  // Stage k feeds iteration k; stage NSTEPS feeds the output section.
  cpc_item_t stg_item  [NSTEPS+1];
  logic      stg_valid [NSTEPS+1];
  logic      stg_ready [NSTEPS+1];

  cpc_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .opcode    (opcode),
    .coord_a   (coord_a),
    .coord_b   (coord_b),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_item  (stg_item[0])
  );

  // One shift-and-add iteration per register stage.
  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    cpc_step #(
      .STEP (i)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_item   (stg_item[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_item  (stg_item[i+1])
    );
  end

  // Gain correction, rounding, clamping and the output register.
  cpc_post u_post (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (stg_valid[NSTEPS]),
    .in_ready           (stg_ready[NSTEPS]),
    .in_item            (stg_item[NSTEPS]),
    .out_valid          (result_valid),
    .out_ready          (result_ready),
    .result_a           (result_a),
    .result_b           (result_b),
    .origin_substituted (origin_substituted)
  );

endmodule
